/* hdl/natural_log_shift_add_defines.svh */
// Assertion macros for the natural log pipeline.
// Needs nothing else; the top level includes it by name.
`ifndef NATURAL_LOG_SHIFT_ADD_DEFINES_SVH
`define NATURAL_LOG_SHIFT_ADD_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NLSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("natural log pipeline check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NLSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("natural log pipeline check failed");

`endif

/* hdl/nlsa_pkg.sv */
// Shared constants, the ln constant table and the stage payload type
// for the natural log pipeline. Depends on nothing.
package nlsa_pkg;

  localparam int X_W                = 24;
  localparam int X_FRAC             = 16;
  localparam int LOG_W              = 29;
  localparam int RESULT_FRAC_BITS   = 24;
  localparam int RESIDUAL_FRAC_BITS = 32;
  localparam int KEY_TOTAL          = 11;
  localparam int NUM_INT_KEYS       = 4;
  localparam int KEY_IDX_W          = $clog2(KEY_TOTAL);
  localparam int START_W            = $clog2(NUM_INT_KEYS);
  localparam int MAX_SHIFT          = 8;
  localparam int XW_EXT             = X_W + RESIDUAL_FRAC_BITS - X_FRAC;
  localparam int M_W                = RESIDUAL_FRAC_BITS + MAX_SHIFT;

  localparam int FRAC_DOWN = (RESIDUAL_FRAC_BITS >= RESULT_FRAC_BITS) ?
                             (RESIDUAL_FRAC_BITS - RESULT_FRAC_BITS) : 0;
  localparam int FRAC_UP   = (RESULT_FRAC_BITS > RESIDUAL_FRAC_BITS) ?
                             (RESULT_FRAC_BITS - RESIDUAL_FRAC_BITS) : 0;
  localparam int SH_W      = RESIDUAL_FRAC_BITS + 1 + FRAC_UP;

  localparam int STAGES = KEY_TOTAL + 1;
  localparam int OCC_W  = $clog2(STAGES + 1);

  localparam int KEY_SHIFT [NUM_INT_KEYS] = '{8, 4, 2, 1};

  // ln(key) rounded to RESULT_FRAC_BITS fraction bits, keys in list order:
  // 256, 16, 4, 2, 3/2, 5/4, 9/8, 17/16, 33/32, 65/64, 129/128.
  localparam logic [LOG_W-1:0] LN_ROM [KEY_TOTAL] = '{
    29'd93032640, 29'd46516320, 29'd23258160, 29'd11629080,
    29'd6802576,  29'd3743728,  29'd1976071,  29'd1017112,
    29'd516263,   29'd260117,   29'd130563
  };

  typedef struct packed {
    logic [START_W-1:0]            start;
    logic [RESIDUAL_FRAC_BITS-1:0] resid;
    logic [LOG_W-1:0]              acc;
  } nlsa_item_t;

endpackage

/* hdl/natural_log_shift_add.sv */
// Natural log unit: takes an unsigned Q8.16 argument and returns ln(x) as a
// signed Q4.24 value by multiplicative normalization. It accepts one request
// per clock cycle unless the output stalls, and each request passes through
// the stages in order: one stage picks the starting key, ten stages each try
// one key with a shift-add and a compare, and one stage forms the final result.
// Ready propagates combinationally back from out_ready_i through every stage,
// so bubbles are squeezed out and a stall loses nothing.
`include "natural_log_shift_add_defines.svh"

module natural_log_shift_add import nlsa_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [X_W-1:0]          x_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [LOG_W-1:0] log_result_o
);

  logic       norm_valid;
  logic       norm_ready;
  nlsa_item_t norm_item;
  logic       chain_valid;
  logic       chain_ready;
  nlsa_item_t chain_item;

  nlsa_norm u_norm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .x_value_i (x_value_i),
    .valid_o   (norm_valid),
    .ready_i   (norm_ready),
    .item_o    (norm_item)
  );

  nlsa_key_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (norm_valid),
    .ready_o (norm_ready),
    .item_i  (norm_item),
    .valid_o (chain_valid),
    .ready_i (chain_ready),
    .item_o  (chain_item)
  );

  nlsa_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (chain_valid),
    .ready_o      (chain_ready),
    .item_i       (chain_item),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .log_result_o (log_result_o)
  );

  // Requests in flight, kept for the checks below.
  logic [OCC_W-1:0] occ_q;
  logic [OCC_W-1:0] occ_d;

  assign occ_d = occ_q + OCC_W'(in_valid_i && in_ready_o)
                       - OCC_W'(out_valid_o && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  `NLSA_ASSERT_NOW(a_ready_follows_out, clk_i, rst_ni, out_ready_i, in_ready_o)
  `NLSA_ASSERT_NOW(a_occ_bound, clk_i, rst_ni, 1'b1, occ_q <= OCC_W'(STAGES))
  `NLSA_ASSERT_NOW(a_no_phantom, clk_i, rst_ni, occ_q == '0, !out_valid_o)
  `NLSA_ASSERT_NOW(a_full_stall, clk_i, rst_ni,
                   occ_q == OCC_W'(STAGES) && !out_ready_i, !in_ready_o)
  `NLSA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(log_result_o))

endmodule

/* hdl/nlsa_norm.sv */
// First pipeline stage: picks the starting power-of-two key and forms the
// initial residual and log. Depends on nlsa_pkg.
module nlsa_norm import nlsa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [X_W-1:0]   x_value_i,
  output logic             valid_o,
  input  logic             ready_i,
  output nlsa_item_t       item_o
);

  logic              valid_q;
  nlsa_item_t        item_q;
  nlsa_item_t        item_d;
  logic [XW_EXT-1:0] x_ext;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    if (x_value_i[X_W-1:X_FRAC+1] == '0) begin
      item_d.start = START_W'(3);
    end else if (x_value_i[X_W-1:X_FRAC+2] == '0) begin
      item_d.start = START_W'(2);
    end else if (x_value_i[X_W-1:X_FRAC+4] == '0) begin
      item_d.start = START_W'(1);
    end else begin
      item_d.start = START_W'(0);
    end
    x_ext        = {x_value_i, {(RESIDUAL_FRAC_BITS - X_FRAC){1'b0}}};
    item_d.resid = RESIDUAL_FRAC_BITS'(x_ext >> KEY_SHIFT[item_d.start]);
    item_d.acc   = LN_ROM[KEY_IDX_W'(item_d.start)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* hdl/nlsa_key_chain.sv */
// Ten pipeline stages, one per later key: each tries to multiply the
// residual by its key and keeps the product if it stays below 1.0 (a
// power-of-two key only after the starting key). Depends on nlsa_pkg.
module nlsa_key_chain import nlsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  nlsa_item_t item_i,
  output logic       valid_o,
  input  logic       ready_i,
  output nlsa_item_t item_o
);

  localparam int NSTG = KEY_TOTAL - 1;

  logic       stg_valid_q [NSTG];
  nlsa_item_t stg_item_q  [NSTG];
  logic       stg_ready   [NSTG];
  logic       src_valid   [NSTG];
  nlsa_item_t src_item    [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    localparam int KEY = s + 1;

    logic       applies;
    logic       keep;
    logic [M_W-1:0] r_ext;
    logic [M_W-1:0] prod;
    nlsa_item_t item_d;

    if (s == 0) begin : g_src_in
      assign src_valid[s] = valid_i;
      assign src_item[s]  = item_i;
    end else begin : g_src_prev
      assign src_valid[s] = stg_valid_q[s-1];
      assign src_item[s]  = stg_item_q[s-1];
    end

    if (s == NSTG - 1) begin : g_rdy_last
      assign stg_ready[s] = !stg_valid_q[s] || ready_i;
    end else begin : g_rdy_mid
      assign stg_ready[s] = !stg_valid_q[s] || stg_ready[s+1];
    end

    assign r_ext   = M_W'(src_item[s].resid);
    assign applies = KEY_IDX_W'(src_item[s].start) < KEY_IDX_W'(KEY);

    if (KEY < NUM_INT_KEYS) begin : g_int_key
      assign prod = r_ext << KEY_SHIFT[KEY];
    end else begin : g_frac_key
      assign prod = r_ext + (r_ext >> (KEY - (NUM_INT_KEYS - 1)));
    end

    assign keep = applies && (prod[M_W-1:RESIDUAL_FRAC_BITS] == '0);

    always_comb begin
      item_d.start = src_item[s].start;
      if (keep) begin
        item_d.resid = prod[RESIDUAL_FRAC_BITS-1:0];
        item_d.acc   = src_item[s].acc - LN_ROM[KEY];
      end else begin
        item_d.resid = src_item[s].resid;
        item_d.acc   = src_item[s].acc;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_valid_q[s] <= 1'b0;
      end else if (stg_ready[s]) begin
        stg_valid_q[s] <= src_valid[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (src_valid[s] && stg_ready[s]) begin
        stg_item_q[s] <= item_d;
      end
    end
  end

  assign ready_o = stg_ready[0];
  assign valid_o = stg_valid_q[NSTG-1];
  assign item_o  = stg_item_q[NSTG-1];

endmodule

/* hdl/nlsa_out.sv */
// Last pipeline stage: subtracts (1 - residual) at result precision from
// the log and holds the result for the output channel. Depends on nlsa_pkg.
module nlsa_out import nlsa_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  nlsa_item_t              item_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [LOG_W-1:0] log_result_o
);

  logic                          valid_q;
  logic [LOG_W-1:0]              log_q;
  logic [LOG_W-1:0]              log_d;
  logic [RESIDUAL_FRAC_BITS:0]   diff;
  logic [SH_W-1:0]               sh;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    diff  = {1'b1, {RESIDUAL_FRAC_BITS{1'b0}}} - {1'b0, item_i.resid};
    sh    = (SH_W'(diff) >> FRAC_DOWN) << FRAC_UP;
    log_d = item_i.acc - LOG_W'(sh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      log_q <= log_d;
    end
  end

  assign valid_o      = valid_q;
  assign log_result_o = $signed(log_q);

endmodule
